@@ hdl/ftvfs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the FIX tag=value field splitter.
// Used by the field logic and the top level.
package ftvfs_pkg;

  // Width of byte offsets and of the running byte position.
  localparam int OFFSET_BITS = 32;
  localparam int TAG_ACC_BITS = 17;
  localparam int COUNT_BITS = 31;

  localparam logic [15:0] TAG_LIMIT = 16'hffff;
  localparam logic [15:0] LEN_LIMIT = 16'hffff;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [TAG_ACC_BITS-1:0] TAG_SAT = TAG_ACC_BITS'(32'h10000);
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] DIGIT_NINE = 8'h39;
  localparam logic [19:0] DEC_BASE = 20'd10;

  localparam logic [7:0] SEPARATOR_RESET = 8'h01;
  localparam logic [7:0] DELIMITER_RESET = 8'h3d;

  // Configuration register select, taken from paddr bit 2.
  localparam logic REG_SEPARATOR = 1'b0;
  localparam logic REG_DELIMITER = 1'b1;

  // Per-message parse state.
  typedef struct packed {
    logic                     in_value;
    logic [OFFSET_BITS-1:0]   pos;
    logic [TAG_ACC_BITS-1:0]  tag_acc;
    logic                     tag_bad;
    logic                     tag_has_digit;
    logic [OFFSET_BITS-1:0]   tag_start;
    logic [OFFSET_BITS-1:0]   value_start;
    logic [COUNT_BITS-1:0]    fields_seen;
  } parse_state_t;

  // Payload of one result transfer.
  typedef struct packed {
    logic                  field_valid;
    logic [15:0]           tag_number;
    logic [31:0]           tag_offset;
    logic [31:0]           value_offset;
    logic [15:0]           value_length;
    logic                  slow_path;
    logic                  message_done;
    logic [COUNT_BITS-1:0] field_count;
  } field_result_t;

endpackage

@@ hdl/ftvfs_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the field splitter's byte input
// and field result output. Depends on nothing but plain logic types.
interface ftvfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, data_byte, end_of_message, input ready);
  modport sink (input valid, data_byte, end_of_message, output ready);
endinterface

interface ftvfs_out_if;
  logic        valid;
  logic        ready;
  logic        field_valid;
  logic [15:0] tag_number;
  logic [31:0] tag_offset;
  logic [31:0] value_offset;
  logic [15:0] value_length;
  logic        slow_path;
  logic        message_done;
  logic [30:0] field_count;

  modport source (output valid, field_valid, tag_number, tag_offset, value_offset,
                  value_length, slow_path, message_done, field_count, input ready);
  modport sink (input valid, field_valid, tag_number, tag_offset, value_offset,
                value_length, slow_path, message_done, field_count, output ready);
endinterface

@@ hdl/fix_tag_value_field_splitter.sv @@
`timescale 1ns / 1ps
// FIX tag=value field splitter top level: input register, parse step, result
// register and APB configuration; depends on ftvfs_pkg, ftvfs_if, ftvfs_field_logic.
// A byte passes the input register, and its result the result register, before that result transfers.
// Throughput: one byte per cycle; input stalls only while a result waits unaccepted
// and the held byte would produce another. Synchronous active-low reset clears the
// parse state and valid flags and restores separator SOH and delimiter '='.
module fix_tag_value_field_splitter
  import ftvfs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  ftvfs_in_if.sink            in_ch,
  ftvfs_out_if.source         out_ch,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  logic [7:0]    separator_r;
  logic [7:0]    delimiter_r;
  logic          s1_valid_r;
  logic [7:0]    s1_byte_r;
  logic          s1_last_r;
  parse_state_t  state_r;
  parse_state_t  state_nxt;
  logic          emit;
  field_result_t result;
  logic          out_valid_r;
  field_result_t out_r;
  logic          out_free;
  logic          s1_advance;
  logic          cfg_write;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      separator_r <= SEPARATOR_RESET;
      delimiter_r <= DELIMITER_RESET;
    end else if (cfg_write) begin
      unique case (cfg_paddr[2])
        REG_SEPARATOR: separator_r <= cfg_pwdata[7:0];
        REG_DELIMITER: delimiter_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_SEPARATOR: cfg_prdata = 32'(separator_r);
      REG_DELIMITER: cfg_prdata = 32'(delimiter_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // Stage handshakes: the input stage moves on when it emits nothing or its result has room.
  assign out_free   = !out_valid_r || out_ch.ready;
  assign s1_advance = s1_valid_r && (!emit || out_free);
  assign in_ch.ready = !s1_valid_r || s1_advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.data_byte;
      s1_last_r <= in_ch.end_of_message;
    end
  end

  // Parse step.
  ftvfs_field_logic u_field_logic (
    .separator_byte (separator_r),
    .delimiter_byte (delimiter_r),
    .data_byte      (s1_byte_r),
    .end_of_message (s1_last_r),
    .state          (state_r),
    .state_nxt      (state_nxt),
    .emit           (emit),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && emit) begin
      out_r <= result;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.field_valid  = out_r.field_valid;
  assign out_ch.tag_number   = out_r.tag_number;
  assign out_ch.tag_offset   = out_r.tag_offset;
  assign out_ch.value_offset = out_r.value_offset;
  assign out_ch.value_length = out_r.value_length;
  assign out_ch.slow_path    = out_r.slow_path;
  assign out_ch.message_done = out_r.message_done;
  assign out_ch.field_count  = out_r.field_count;

  // A result without a field is only the end-of-message report.
  a_empty_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.field_valid) |-> out_r.message_done)
    else $error("result without field and without message end");

  // Slow-path fields carry no tag number.
  a_slow_no_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.slow_path) |-> (out_r.tag_number == 16'd0))
    else $error("slow-path field carries a tag number");

  // Consuming the last byte of a message restarts the byte position.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_advance && s1_last_r) |=> (state_r.pos == '0) && !state_r.in_value)
    else $error("parse state not cleared after message end");

  // The input stage never drops a byte it holds while the output is stalled.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && emit && !out_free) |=> (s1_valid_r && $stable(s1_byte_r)))
    else $error("held byte lost under output stall");

endmodule

@@ hdl/ftvfs_field_logic.sv @@
`timescale 1ns / 1ps
// Combinational parse step: one byte against the current parse state.
// Depends on ftvfs_pkg for the state and result structs.
module ftvfs_field_logic
  import ftvfs_pkg::*;
(
  input  logic [7:0]    separator_byte,
  input  logic [7:0]    delimiter_byte,
  input  logic [7:0]    data_byte,
  input  logic          end_of_message,
  input  parse_state_t  state,
  output parse_state_t  state_nxt,
  output logic          emit,
  output field_result_t result
);

  logic [OFFSET_BITS-1:0] pos_inc;
  logic [OFFSET_BITS-1:0] len;
  logic [31:0]            len_ext;
  logic                   len_over;
  logic                   is_digit;
  logic [19:0]            acc_next;
  logic                   field_done;
  logic                   bad;
  logic [COUNT_BITS-1:0]  count_inc;

  // Shared arithmetic for the step.
  assign pos_inc  = state.pos + OFFSET_BITS'(1);
  assign len      = state.pos - state.value_start;
  assign len_ext  = 32'(len);
  assign len_over = len_ext > 32'(LEN_LIMIT);
  assign is_digit = (data_byte >= DIGIT_ZERO) && (data_byte <= DIGIT_NINE);
  assign acc_next = 20'(state.tag_acc) * DEC_BASE + 20'(data_byte - DIGIT_ZERO);
  assign field_done = state.in_value && (data_byte == separator_byte);
  assign bad = state.tag_bad || !state.tag_has_digit ||
               (state.tag_acc > TAG_ACC_BITS'(TAG_LIMIT)) || len_over;
  assign count_inc = (state.fields_seen < COUNT_MAX) ?
                     state.fields_seen + COUNT_BITS'(1) : state.fields_seen;

  // Next parse state; the last byte of a message returns it to reset.
  always_comb begin
    state_nxt = state;
    if (!state.in_value) begin
      if (data_byte == delimiter_byte) begin
        state_nxt.in_value    = 1'b1;
        state_nxt.value_start = pos_inc;
      end else if (is_digit) begin
        state_nxt.tag_acc = (acc_next > 20'(TAG_LIMIT)) ? TAG_SAT :
                            acc_next[TAG_ACC_BITS-1:0];
        state_nxt.tag_has_digit = 1'b1;
      end else begin
        state_nxt.tag_bad = 1'b1;
      end
    end else if (field_done) begin
      state_nxt.fields_seen   = count_inc;
      state_nxt.in_value      = 1'b0;
      state_nxt.tag_acc       = '0;
      state_nxt.tag_bad       = 1'b0;
      state_nxt.tag_has_digit = 1'b0;
      state_nxt.tag_start     = pos_inc;
    end
    state_nxt.pos = pos_inc;
    if (end_of_message) begin
      state_nxt = '0;
    end
  end

  // Result payload for a completed field or the message end.
  always_comb begin
    result = '0;
    result.message_done = end_of_message;
    result.field_count  = field_done ? count_inc : state.fields_seen;
    if (field_done) begin
      result.field_valid  = 1'b1;
      result.slow_path    = bad;
      result.tag_number   = bad ? 16'd0 : state.tag_acc[15:0];
      result.tag_offset   = 32'(state.tag_start);
      result.value_offset = 32'(state.value_start);
      result.value_length = len_over ? LEN_LIMIT : len_ext[15:0];
    end
  end

  assign emit = field_done || end_of_message;

endmodule
